@@ rtl/core/mrgs_pkg.sv @@
// Shared types for the merge sorter: sequencer state encoding.
`default_nettype none

package mrgs_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_MERGE,
        ST_OUT
    } mrgs_state_t;

endpackage

`default_nettype wire

@@ rtl/core/merge_sorter_unit.sv @@
// Merge sorter top level: collection store, bottom-up merge sequencer and result read-out.
`default_nettype none

// Values are taken one per cycle with start while busy is low; each gives no result. The
// transfer flagged final_item stores its value if there is room (further values beyond
// MAX_ITEMS are dropped and mark the run as overflowed), then busy rises. The n held values
// are sorted by ceil(log2(n)) bottom-up merge passes that ping-pong between two memories; in
// each pass the prime state loads the two read ports, after which one element is merged per
// cycle, limited by the single write port of the destination memory. The n results then
// follow one per cycle, starting the cycle after busy enters read-out, each marked by strobe
// for a single cycle; the receiver cannot hold them off.
module merge_sorter_unit
    import mrgs_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] sample_value,
    input  wire logic               final_item,
    output logic                    strobe,
    output logic signed [31:0]      sorted_value,
    output logic                    end_of_run,
    output logic                    overflowed
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] CAPACITY = CW'(MAX_ITEMS);

    mrgs_state_t state_reg, state_next;

    logic [CW-1:0] held_reg, held_next;
    logic          drop_reg, drop_next;
    logic [WW-1:0] width_reg, width_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic          src_pri_reg, src_pri_next;
    logic          strobe_reg, strobe_next;
    logic          last_reg, last_next;
    logic          ovf_reg, ovf_next;

    logic [31:0] pri_mem [MAX_ITEMS];
    logic [31:0] scr_mem [MAX_ITEMS];
    logic [31:0] pri_qa_reg, pri_qb_reg, scr_qa_reg, scr_qb_reg;

    logic [AW-1:0] rd_a_addr, rd_b_addr;
    logic          pri_we, scr_we;
    logic [AW-1:0] pri_wa;
    logic [31:0]   pri_wd;

    logic          accept;
    logic          room;
    logic [CW-1:0] held_inc;
    logic [CW-1:0] n_new;
    logic [SW-1:0] n_ext;
    logic [31:0]   qa, qb;
    logic          take_a;
    logic [31:0]   merge_word;
    logic [CW-1:0] k_inc;
    logic          pass_end, run_end;
    logic [WW-1:0] width_dbl;
    logic [SW-1:0] run_mid, run_hi, pass_mid, pass_hi, first_hi;
    logic [CW-1:0] run_mid_c, run_hi_c, pass_mid_c, pass_hi_c, first_hi_c;
    logic          sort_done;

    assign accept   = start && !busy;
    assign room     = held_reg < CAPACITY;
    assign held_inc = held_reg + CW'(1);
    assign n_new    = room ? held_inc : held_reg;
    assign n_ext    = SW'(held_reg);

    assign qa = src_pri_reg ? pri_qa_reg : scr_qa_reg;
    assign qb = src_pri_reg ? pri_qb_reg : scr_qb_reg;

    // Left run wins ties, so the merge stays stable.
    assign take_a     = !(j_reg < hi_reg) ||
                        ((i_reg < mid_reg) && ($signed(qa) <= $signed(qb)));
    assign merge_word = take_a ? qa : qb;

    assign k_inc    = k_reg + CW'(1);
    assign pass_end = (k_inc == held_reg);
    assign run_end  = (k_inc == hi_reg);

    // Bounds of the next run within a pass, clipped to the set size.
    assign run_mid   = SW'(hi_reg) + SW'(width_reg);
    assign run_hi    = SW'(hi_reg) + (SW'(width_reg) << 1);
    assign run_mid_c = (run_mid > n_ext) ? held_reg : run_mid[CW-1:0];
    assign run_hi_c  = (run_hi > n_ext) ? held_reg : run_hi[CW-1:0];

    // Bounds of the first run of the following pass.
    assign width_dbl  = width_reg << 1;
    assign pass_mid   = SW'(width_dbl);
    assign pass_hi    = SW'(width_dbl) << 1;
    assign pass_mid_c = (pass_mid > n_ext) ? held_reg : pass_mid[CW-1:0];
    assign pass_hi_c  = (pass_hi > n_ext) ? held_reg : pass_hi[CW-1:0];
    assign sort_done  = (pass_mid >= n_ext);

    assign first_hi   = SW'(2);
    assign first_hi_c = (first_hi > SW'(n_new)) ? n_new : first_hi[CW-1:0];

    assign busy         = (state_reg != ST_IDLE);
    assign strobe       = strobe_reg;
    assign end_of_run   = last_reg;
    assign overflowed   = ovf_reg;
    assign sorted_value = src_pri_reg ? $signed(pri_qa_reg) : $signed(scr_qa_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && final_item)
                begin
                    state_next = (n_new > CW'(1)) ? ST_PRIME : ST_OUT;
                end
            end
            ST_PRIME:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (pass_end)
                begin
                    state_next = sort_done ? ST_OUT : ST_PRIME;
                end
            end
            ST_OUT:
            begin
                if (pass_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        held_next    = held_reg;
        drop_next    = drop_reg;
        width_next   = width_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        src_pri_next = src_pri_reg;
        strobe_next  = 1'b0;
        last_next    = 1'b0;
        ovf_next     = ovf_reg;
        rd_a_addr    = '0;
        rd_b_addr    = '0;
        pri_we       = 1'b0;
        pri_wa       = held_reg[AW-1:0];
        pri_wd       = sample_value;
        scr_we       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        pri_we    = 1'b1;
                        held_next = held_inc;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (final_item)
                    begin
                        width_next   = WW'(1);
                        i_next       = '0;
                        j_next       = CW'(1);
                        k_next       = '0;
                        mid_next     = CW'(1);
                        hi_next      = first_hi_c;
                        src_pri_next = 1'b1;
                    end
                end
            end
            ST_PRIME:
            begin
                rd_a_addr = i_reg[AW-1:0];
                rd_b_addr = j_reg[AW-1:0];
            end
            ST_MERGE:
            begin
                pri_wa = k_reg[AW-1:0];
                pri_wd = merge_word;
                pri_we = !src_pri_reg;
                scr_we = src_pri_reg;
                i_next = take_a ? i_reg + CW'(1) : i_reg;
                j_next = take_a ? j_reg : j_reg + CW'(1);
                k_next = k_inc;
                if (pass_end)
                begin
                    width_next   = width_dbl;
                    src_pri_next = !src_pri_reg;
                    k_next       = '0;
                    i_next       = '0;
                    mid_next     = pass_mid_c;
                    j_next       = pass_mid_c;
                    hi_next      = pass_hi_c;
                end
                else if (run_end)
                begin
                    i_next   = hi_reg;
                    mid_next = run_mid_c;
                    j_next   = run_mid_c;
                    hi_next  = run_hi_c;
                end
                rd_a_addr = i_next[AW-1:0];
                rd_b_addr = j_next[AW-1:0];
            end
            ST_OUT:
            begin
                rd_a_addr   = k_reg[AW-1:0];
                strobe_next = 1'b1;
                last_next   = pass_end;
                ovf_next    = drop_reg;
                k_next      = k_inc;
                if (pass_end)
                begin
                    held_next = '0;
                    drop_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            held_reg    <= '0;
            drop_reg    <= 1'b0;
            width_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            src_pri_reg <= 1'b1;
            strobe_reg  <= 1'b0;
            last_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            drop_reg    <= drop_next;
            width_reg   <= width_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            mid_reg     <= mid_next;
            hi_reg      <= hi_next;
            src_pri_reg <= src_pri_next;
            strobe_reg  <= strobe_next;
            last_reg    <= last_next;
            ovf_reg     <= ovf_next;
        end
    end

    // Two synchronous memories, one write port and two read ports each.
    always_ff @(posedge clk)
    begin
        if (pri_we)
        begin
            pri_mem[pri_wa] <= pri_wd;
        end
        pri_qa_reg <= pri_mem[rd_a_addr];
        pri_qb_reg <= pri_mem[rd_b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
        begin
            scr_mem[k_reg[AW-1:0]] <= merge_word;
        end
        scr_qa_reg <= scr_mem[rd_a_addr];
        scr_qb_reg <= scr_mem[rd_b_addr];
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CAPACITY)
        else $error("held count exceeds capacity");

    a_merge_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> (k_reg < held_reg && i_reg <= mid_reg && j_reg <= hi_reg))
        else $error("merge index out of run bounds");

    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == ST_OUT))
        else $error("result strobe outside read-out");

    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |-> (state_reg == ST_IDLE && held_reg == '0))
        else $error("final result while set still held");

    a_drop_set: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !room && !final_item) |=> drop_reg)
        else $error("dropped transfer not flagged");

endmodule

`default_nettype wire
